>>> rtl/page_run_allocator_exact_worst_fit_assert.svh
// assertion macros for the page run allocator
`ifndef PAGE_RUN_ALLOCATOR_EXACT_WORST_FIT_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_EXACT_WORST_FIT_ASSERT_SVH

// same-cycle implication
`define PRWF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRWF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/prwf_pkg.sv
// shared types and constants of the page run allocator
`default_nettype none

package prwf_pkg;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CNT_W     = PAGE_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END     = CFG_IDX_W'(1);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_EXACT   = 3'd0,
        ST_WORST   = 3'd1,
        ST_EXTEND  = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_FREED   = 3'd4,
        ST_IGNORED = 3'd5,
        ST_INVALID = 3'd6
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [CNT_W-1:0]  pages_requested;
        logic [PAGE_W-1:0] target_page;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] run_page;
        logic [CNT_W-1:0]  break_now;
    } t_out_beat;

    typedef struct packed {
        logic [PAGE_W-1:0] region_start_page;
        logic [CNT_W-1:0]  heap_end_page;
    } t_cfg;

    typedef struct packed {
        logic             set;
        logic [CNT_W-1:0] page;
    } t_brk_set;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic [PAGE_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/page_run_allocator_exact_worst_fit.sv
// Allocate: scans the run table from region start up to the break, stopping early on an exact fit.
// Free: clears the run's entry; a topmost free walks back over the entries to recover the break.
// The registered read port of the run table memory paces each scan step.
// One command in flight; the next is taken while the finished result waits in the output register.
// Reset: a clearing pass writes zero to all NUM_PAGES entries, input stalled meanwhile.
// Registers reset to region start 0, heap end 1024, break 0; config writes are taken at any time.
`default_nettype none

`include "page_run_allocator_exact_worst_fit_assert.svh"

module page_run_allocator_exact_worst_fit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire prwf_pkg::t_in_beat            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output prwf_pkg::t_out_beat                o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [prwf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [prwf_pkg::CNT_W-1:0]     i_cfg_data
);

    import prwf_pkg::*;

    logic              r_out_valid;
    t_out_beat         r_out_data;
    logic [PAGE_W-1:0] r_region;
    logic [CNT_W-1:0]  r_heap;

    logic              w_busy;
    logic              w_cfg_wr;
    logic              w_take;
    t_cfg              w_cfg;
    t_brk_set          w_brk_set;
    t_mem_req          w_mem_req;
    logic [CNT_W-1:0]  w_rdata;
    t_res              w_res;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= '0;
            r_heap   <= CNT_W'(NUM_PAGES);
        end else if (w_cfg_wr) begin
            if (i_cfg_index == CFG_REGION_START) begin
                r_region <= i_cfg_data[PAGE_W-1:0];
            end else if (i_cfg_index == CFG_HEAP_END) begin
                r_heap <= i_cfg_data;
            end
        end
    end

    assign w_cfg.region_start_page = r_region;
    assign w_cfg.heap_end_page     = r_heap;
    assign w_brk_set.set  = w_cfg_wr && (i_cfg_index == CFG_REGION_START);
    assign w_brk_set.page = {1'b0, i_cfg_data[PAGE_W-1:0]};

    prwf_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_data),
        .o_busy     (w_busy),
        .i_cfg      (w_cfg),
        .i_brk_set  (w_brk_set),
        .o_mem_req  (w_mem_req),
        .i_rdata    (w_rdata),
        .o_res      (w_res),
        .i_res_take (w_take)
    );

    prwf_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (CNT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_waddr (w_mem_req.waddr),
        .i_wdata (w_mem_req.wdata),
        .i_raddr (w_mem_req.raddr),
        .o_rdata (w_rdata)
    );

    // output beat register
    assign w_take = w_res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_data <= w_res.beat;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `PRWF_ASSERT_IMP(a_alloc_below_break,
        o_out_valid && (o_out_data.status == ST_EXACT || o_out_data.status == ST_WORST ||
                        o_out_data.status == ST_EXTEND),
        o_out_data.break_now > CNT_W'(o_out_data.run_page),
        "allocated run does not lie below the break")
    `PRWF_ASSERT_IMP(a_no_page_on_fail,
        o_out_valid && (o_out_data.status == ST_NOSPACE || o_out_data.status == ST_FREED ||
                        o_out_data.status == ST_IGNORED || o_out_data.status == ST_INVALID),
        o_out_data.run_page == '0,
        "run page set on a beat without an allocation")
    `PRWF_ASSERT_IMP(a_break_in_table,
        o_out_valid,
        o_out_data.break_now <= CNT_W'(NUM_PAGES),
        "break beyond the run table")
    `PRWF_ASSERT_NXT(a_busy_after_accept,
        i_in_valid && !o_in_stall,
        o_in_stall,
        "command accepted but engine not busy")

endmodule

`default_nettype wire

>>> rtl/prwf_ram.sv
// run table storage, one write and one registered read port
`default_nettype none

module prwf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/prwf_engine.sv
// command sequencer: table clear, allocate scan, free and break recovery
`default_nettype none

module prwf_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire prwf_pkg::t_in_beat        i_in_beat,
    output logic                           o_busy,
    input  wire prwf_pkg::t_cfg            i_cfg,
    input  wire prwf_pkg::t_brk_set        i_brk_set,
    output prwf_pkg::t_mem_req             o_mem_req,
    input  wire logic [prwf_pkg::CNT_W-1:0] i_rdata,
    output prwf_pkg::t_res                 o_res,
    input  wire logic                      i_res_take
);

    import prwf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_FIN,
        S_F_RD,
        S_F_EV,
        S_B_RD,
        S_B_EV,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [PAGE_W-1:0] r_t, n_t;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_best, n_best;
    logic [PAGE_W-1:0] r_at, n_at;
    t_status           r_kind, n_kind;
    logic [CNT_W-1:0]  r_brk, n_brk;
    logic [PAGE_W-1:0] r_b, n_b;
    logic [PAGE_W-1:0] r_clr, n_clr;
    t_out_beat         r_out, n_out;

    logic [CNT_W-1:0]  w_end;
    logic [CNT_W-1:0]  w_room;
    logic [CNT_W:0]    w_top;
    logic [CNT_W-1:0]  w_brk_new;

    always_comb begin
        w_end  = (i_cfg.heap_end_page < CNT_W'(NUM_PAGES)) ? i_cfg.heap_end_page
                                                            : CNT_W'(NUM_PAGES);
        w_room = (w_end > r_brk) ? (w_end - r_brk) : '0;
        w_top  = {2'b00, r_t} + {1'b0, i_rdata};
        w_brk_new = {1'b0, r_b} + i_rdata;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_t     = r_t;
        n_i     = r_i;
        n_cnt   = r_cnt;
        n_best  = r_best;
        n_at    = r_at;
        n_kind  = r_kind;
        n_brk   = r_brk;
        n_b     = r_b;
        n_clr   = r_clr;
        n_out   = r_out;

        o_mem_req       = '0;
        o_mem_req.raddr = r_i[PAGE_W-1:0];

        case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = '0;
                n_clr = r_clr + PAGE_W'(1);
                if (r_clr == PAGE_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n = i_in_beat.pages_requested;
                    n_t = i_in_beat.target_page;
                    if (i_in_beat.cmd == CMD_ALLOC) begin
                        if (i_in_beat.pages_requested == '0) begin
                            n_out   = '{status: ST_NOSPACE, run_page: '0, break_now: r_brk};
                            n_state = S_DONE;
                        end else begin
                            n_i     = {1'b0, i_cfg.region_start_page};
                            n_cnt   = '0;
                            n_best  = '0;
                            n_at    = '0;
                            n_kind  = ST_NOSPACE;
                            n_state = S_A_RD;
                        end
                    end else if (i_in_beat.target_page < i_cfg.region_start_page ||
                                 {1'b0, i_in_beat.target_page} >= r_brk) begin
                        n_out   = '{status: ST_INVALID, run_page: '0, break_now: r_brk};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                o_mem_req.raddr = r_i[PAGE_W-1:0];
                n_state = (r_i < r_brk) ? S_A_EV : S_A_FIN;
            end
            S_A_EV: begin
                if (i_rdata == '0) begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_A_RD;
                end else if (r_cnt == r_n) begin
                    n_at    = PAGE_W'(r_i - r_cnt);
                    n_kind  = ST_EXACT;
                    n_state = S_A_FIN;
                end else begin
                    if (r_cnt > r_best && r_cnt > r_n) begin
                        n_best = r_cnt;
                        n_at   = PAGE_W'(r_i - r_cnt);
                        n_kind = ST_WORST;
                    end
                    n_cnt   = '0;
                    n_i     = r_i + i_rdata;
                    n_state = S_A_RD;
                end
            end
            S_A_FIN: begin
                n_state = S_DONE;
                if (r_kind == ST_NOSPACE) begin
                    if (r_n > w_room) begin
                        n_out = '{status: ST_NOSPACE, run_page: '0, break_now: r_brk};
                    end else begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_brk[PAGE_W-1:0];
                        o_mem_req.wdata = r_n;
                        n_brk = r_brk + r_n;
                        n_out = '{status: ST_EXTEND, run_page: r_brk[PAGE_W-1:0],
                                  break_now: r_brk + r_n};
                    end
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_at;
                    o_mem_req.wdata = r_n;
                    n_out = '{status: r_kind, run_page: r_at, break_now: r_brk};
                end
            end
            S_F_RD: begin
                o_mem_req.raddr = r_t;
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (i_rdata == '0) begin
                    n_out   = '{status: ST_IGNORED, run_page: '0, break_now: r_brk};
                    n_state = S_DONE;
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_t;
                    o_mem_req.wdata = '0;
                    if (w_top == {1'b0, r_brk}) begin
                        n_brk   = {1'b0, i_cfg.region_start_page};
                        n_b     = r_t;
                        n_state = S_B_RD;
                    end else begin
                        n_out   = '{status: ST_FREED, run_page: '0, break_now: r_brk};
                        n_state = S_DONE;
                    end
                end
            end
            S_B_RD: begin
                if (r_b > i_cfg.region_start_page) begin
                    n_b             = r_b - PAGE_W'(1);
                    o_mem_req.raddr = r_b - PAGE_W'(1);
                    n_state         = S_B_EV;
                end else begin
                    n_out   = '{status: ST_FREED, run_page: '0, break_now: r_brk};
                    n_state = S_DONE;
                end
            end
            S_B_EV: begin
                if (i_rdata != '0) begin
                    n_brk   = w_brk_new;
                    n_out   = '{status: ST_FREED, run_page: '0, break_now: w_brk_new};
                    n_state = S_DONE;
                end else begin
                    n_state = S_B_RD;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // region start write moves the break
        if (i_brk_set.set) begin
            n_brk = i_brk_set.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_brk   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_brk   <= n_brk;
        end
        r_n    <= n_n;
        r_t    <= n_t;
        r_i    <= n_i;
        r_cnt  <= n_cnt;
        r_best <= n_best;
        r_at   <= n_at;
        r_kind <= n_kind;
        r_b    <= n_b;
        r_out  <= n_out;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.beat  = r_out;

endmodule

`default_nettype wire
